// File: rtl/fcgv_pkg.sv
// ----------------------------------------------------------------------------
// fcgv_pkg: shared types and helpers for the frame check generate/verify unit
// Method and result-kind codes, the result record, control bundle, CRC step.
// ----------------------------------------------------------------------------
package fcgv_pkg;

  localparam logic [1:0] METHOD_EVEN   = 2'd0;
  localparam logic [1:0] METHOD_ODD    = 2'd1;
  localparam logic [1:0] METHOD_CKSUM  = 2'd2;
  localparam logic [1:0] METHOD_CRC    = 2'd3;

  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_TRAILER  = 2'd1;
  localparam logic [1:0] KIND_VERDICT  = 2'd2;

  localparam logic DIR_SENDER   = 1'b0;
  localparam logic DIR_RECEIVER = 1'b1;

  localparam logic [1:0] REG_METHOD    = 2'd0;
  localparam logic [1:0] REG_DIRECTION = 2'd1;
  localparam logic [1:0] REG_CRC_POLY  = 2'd2;
  localparam logic [1:0] REG_CRC_INIT  = 2'd3;

  localparam logic [1:0]  RESET_METHOD    = METHOD_CRC;
  localparam logic        RESET_DIRECTION = DIR_SENDER;
  localparam logic [15:0] RESET_CRC_POLY  = 16'h1021;
  localparam logic [15:0] RESET_CRC_INIT  = 16'hFFFF;

  localparam int RES_DEPTH = 3;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       last;
    logic       ok;
  } result_t;

  typedef struct packed {
    logic [1:0]  method;
    logic        direction;
    logic [15:0] crc_poly;
    logic [15:0] crc_init;
    logic        init_load;
    logic [15:0] init_wdata;
  } ctl_t;

  // MSB-first CRC-16 over one byte, eight shift steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b,
                                           input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ poly;
      else       c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // one's-complement add with end-around carry
  function automatic logic [15:0] fold_add(input logic [15:0] s, input logic [15:0] w);
    logic [16:0] t;
    t = {1'b0, s} + {1'b0, w};
    if (t[16]) return t[15:0] + 16'd1;
    else       return t[15:0];
  endfunction

endpackage

// File: rtl/fcgv_engine.sv
// ----------------------------------------------------------------------------
// fcgv_engine: frame check state and per-byte result generation
// Holds parity, checksum and CRC state plus the receiver delay line, and
// forms the zero to three results of each accepted byte in one pass.
// ----------------------------------------------------------------------------
module fcgv_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  fcgv_pkg::ctl_t      ctl,
  input  logic                acc,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output fcgv_pkg::result_t   res [fcgv_pkg::RES_DEPTH],
  output logic [1:0]          res_cnt
);

  logic [15:0] crc_r, crc_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic        par_r, par_nxt;
  logic        odd_r, odd_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [7:0]  dl0_r, dl1_r, dl0_nxt, dl1_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic        mid_r, mid_nxt;

  logic        sender, tlen2, do_abs;
  logic [1:0]  tlen;
  logic [7:0]  abs_byte;
  logic [15:0] crc_a, sum_a, chk, sum_pad;
  logic        par_a, odd_a;
  logic [7:0]  held_a;
  logic [2:0]  fill_inc;
  logic [1:0]  fill_new;
  logic        ok;
  fcgv_pkg::result_t pay_res, ver_res;

  always_comb begin
    sender   = (ctl.direction == fcgv_pkg::DIR_SENDER);
    tlen2    = (ctl.method == fcgv_pkg::METHOD_CKSUM) || (ctl.method == fcgv_pkg::METHOD_CRC);
    tlen     = tlen2 ? 2'd2 : 2'd1;
    do_abs   = sender || (fill_r >= tlen);
    abs_byte = sender ? in_byte : (tlen2 ? dl1_r : dl0_r);

    // absorb the byte into every check
    crc_a  = crc_r;
    sum_a  = sum_r;
    par_a  = par_r;
    odd_a  = odd_r;
    held_a = held_r;
    if (do_abs) begin
      crc_a = fcgv_pkg::crc_byte(crc_r, abs_byte, ctl.crc_poly);
      par_a = par_r ^ (^abs_byte);
      if (odd_r) begin
        sum_a = fcgv_pkg::fold_add(sum_r, {held_r, abs_byte});
        odd_a = 1'b0;
      end else begin
        held_a = abs_byte;
        odd_a  = 1'b1;
      end
    end

    // pad an odd final byte as the high half
    sum_pad = odd_a ? fcgv_pkg::fold_add(sum_a, {held_a, 8'h00}) : sum_a;
    case (ctl.method)
      fcgv_pkg::METHOD_EVEN:  chk = {15'd0, par_a};
      fcgv_pkg::METHOD_ODD:   chk = {15'd0, ~par_a};
      fcgv_pkg::METHOD_CKSUM: chk = ~sum_pad;
      default:                chk = crc_a;
    endcase

    fill_inc = {1'b0, fill_r} + 3'd1;
    fill_new = (fill_inc > {1'b0, tlen}) ? tlen : fill_inc[1:0];
    if (fill_new < tlen) ok = 1'b0;
    else if (tlen2)      ok = ({dl0_r, in_byte} == chk);
    else                 ok = (in_byte[0] == chk[0]);

    pay_res = '{data: abs_byte, kind: fcgv_pkg::KIND_PAYLOAD, last: 1'b0, ok: 1'b0};
    ver_res = '{data: 8'h00, kind: fcgv_pkg::KIND_VERDICT, last: 1'b1, ok: ok};

    res[0] = pay_res;
    res[1] = ver_res;
    res[2] = ver_res;
    if (sender) begin
      if (!in_last) begin
        res_cnt = 2'd1;
      end else if (!tlen2) begin
        res[1]  = '{data: {7'd0, chk[0]}, kind: fcgv_pkg::KIND_TRAILER, last: 1'b1, ok: 1'b0};
        res_cnt = 2'd2;
      end else begin
        res[1]  = '{data: chk[15:8], kind: fcgv_pkg::KIND_TRAILER, last: 1'b0, ok: 1'b0};
        res[2]  = '{data: chk[7:0], kind: fcgv_pkg::KIND_TRAILER, last: 1'b1, ok: 1'b0};
        res_cnt = 2'd3;
      end
    end else begin
      if (!do_abs) res[0] = ver_res;
      res_cnt = {1'b0, do_abs} + {1'b0, in_last};
    end
  end

  always_comb begin
    crc_nxt  = crc_r;
    sum_nxt  = sum_r;
    par_nxt  = par_r;
    odd_nxt  = odd_r;
    held_nxt = held_r;
    dl0_nxt  = dl0_r;
    dl1_nxt  = dl1_r;
    fill_nxt = fill_r;
    mid_nxt  = mid_r;
    if (acc) begin
      if (in_last) begin
        // frame done: back to the start-of-frame state
        crc_nxt  = ctl.crc_init;
        sum_nxt  = 16'd0;
        par_nxt  = 1'b0;
        odd_nxt  = 1'b0;
        held_nxt = 8'd0;
        fill_nxt = 2'd0;
        mid_nxt  = 1'b0;
      end else begin
        crc_nxt  = crc_a;
        sum_nxt  = sum_a;
        par_nxt  = par_a;
        odd_nxt  = odd_a;
        held_nxt = held_a;
        mid_nxt  = 1'b1;
        if (!sender) begin
          dl1_nxt  = dl0_r;
          dl0_nxt  = in_byte;
          fill_nxt = fill_new;
        end
      end
    end else if (ctl.init_load && !mid_r) begin
      crc_nxt = ctl.init_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= fcgv_pkg::RESET_CRC_INIT;
      sum_r  <= 16'd0;
      par_r  <= 1'b0;
      odd_r  <= 1'b0;
      held_r <= 8'd0;
      fill_r <= 2'd0;
      mid_r  <= 1'b0;
    end else begin
      crc_r  <= crc_nxt;
      sum_r  <= sum_nxt;
      par_r  <= par_nxt;
      odd_r  <= odd_nxt;
      held_r <= held_nxt;
      fill_r <= fill_nxt;
      mid_r  <= mid_nxt;
    end
  end

  // delay line: contents matter only once the fill count covers them
  always_ff @(posedge clk) begin
    dl0_r <= dl0_nxt;
    dl1_r <= dl1_nxt;
  end

endmodule

// File: rtl/frame_check_generate_verify_unit.sv
// ----------------------------------------------------------------------------
// frame_check_generate_verify_unit: parity/checksum/CRC frame trailer unit
// A byte's results (zero to three) leave a result buffer one per cycle while
// out_stall is low, presented from the cycle after acceptance. The next byte is taken at
// the edge of the last result's transfer: one byte per cycle while each byte
// yields at most one result and the result side does not stall.
// Synchronous active-low reset restores register defaults and frame state.
// ----------------------------------------------------------------------------
module frame_check_generate_verify_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_kind,
  output logic        out_last,
  output logic        out_frame_ok,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0]  method_r;
  logic        direction_r;
  logic [15:0] crc_poly_r;
  logic [15:0] crc_init_r;

  logic              cfg_wr;
  logic              in_acc, pop;
  fcgv_pkg::ctl_t    ctl;
  fcgv_pkg::result_t eng_res [fcgv_pkg::RES_DEPTH];
  logic [1:0]        eng_cnt;

  fcgv_pkg::result_t res_r [fcgv_pkg::RES_DEPTH];
  logic [1:0]        rem_r, rem_nxt;
  logic [1:0]        rd_idx_r, rd_idx_nxt;
  fcgv_pkg::result_t cur;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_r    <= fcgv_pkg::RESET_METHOD;
      direction_r <= fcgv_pkg::RESET_DIRECTION;
      crc_poly_r  <= fcgv_pkg::RESET_CRC_POLY;
      crc_init_r  <= fcgv_pkg::RESET_CRC_INIT;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        fcgv_pkg::REG_METHOD:    method_r    <= pwdata[1:0];
        fcgv_pkg::REG_DIRECTION: direction_r <= pwdata[0];
        fcgv_pkg::REG_CRC_POLY:  crc_poly_r  <= pwdata[15:0];
        fcgv_pkg::REG_CRC_INIT:  crc_init_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      fcgv_pkg::REG_METHOD:    prdata = {30'd0, method_r};
      fcgv_pkg::REG_DIRECTION: prdata = {31'd0, direction_r};
      fcgv_pkg::REG_CRC_POLY:  prdata = {16'd0, crc_poly_r};
      fcgv_pkg::REG_CRC_INIT:  prdata = {16'd0, crc_init_r};
      default:                 prdata = 32'd0;
    endcase
  end

  always_comb begin
    ctl.method     = method_r;
    ctl.direction  = direction_r;
    ctl.crc_poly   = crc_poly_r;
    ctl.crc_init   = crc_init_r;
    ctl.init_load  = cfg_wr && (paddr[3:2] == fcgv_pkg::REG_CRC_INIT);
    ctl.init_wdata = pwdata[15:0];
  end

  fcgv_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .acc     (in_acc),
    .in_byte (in_byte),
    .in_last (in_last),
    .res     (eng_res),
    .res_cnt (eng_cnt)
  );

  // result buffer: take a new transaction when empty or as the last buffered result leaves
  assign out_valid = (rem_r != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign in_stall  = (rem_r != 2'd0) && !((rem_r == 2'd1) && pop);
  assign in_acc    = in_valid && !in_stall;

  always_comb begin
    rem_nxt    = rem_r;
    rd_idx_nxt = rd_idx_r;
    if (in_acc) begin
      rem_nxt    = eng_cnt;
      rd_idx_nxt = 2'd0;
    end else if (pop) begin
      rem_nxt    = rem_r - 2'd1;
      rd_idx_nxt = (rem_r == 2'd1) ? 2'd0 : rd_idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r    <= 2'd0;
      rd_idx_r <= 2'd0;
    end else begin
      rem_r    <= rem_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= eng_res;
    end
  end

  assign cur          = res_r[rd_idx_r];
  assign out_byte     = cur.data;
  assign out_kind     = cur.kind;
  assign out_last     = cur.last;
  assign out_frame_ok = cur.ok;

`ifndef SYNTHESIS
  a_buf_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r != 2'd0) |-> (({1'b0, rd_idx_r} + {1'b0, rem_r}) <= 3'd3))
    else $error("result buffer read index runs past its entries");

  a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == fcgv_pkg::KIND_VERDICT)) |-> out_last)
    else $error("verdict without frame end marker");

  a_ok_only_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind != fcgv_pkg::KIND_VERDICT)) |-> !out_frame_ok)
    else $error("frame_ok set on a non-verdict result");

  a_trailer_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && (out_kind == fcgv_pkg::KIND_TRAILER) && !out_last)
      |=> (out_valid && (out_kind == fcgv_pkg::KIND_TRAILER)))
    else $error("high trailer byte not followed by low trailer byte");
`endif

endmodule

// File: test/fcgv_result_checker.sv
// ----------------------------------------------------------------------------
// fcgv_result_checker: result predictor and scoreboard for the frame check unit
// Tracks register writes on the configuration port and every accepted input
// transaction, predicts the payload, trailer and verdict results, and compares
// each accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcgv_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic [1:0]  out_kind,
  input  logic        out_last,
  input  logic        out_frame_ok,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending_count
);

  // shadow registers
  logic [1:0]  method_q;
  logic        dir_q;
  logic [15:0] poly_q;
  logic [15:0] init_q;

  // running frame state
  logic [15:0] crc_q;
  logic [15:0] sum_q;
  logic        par_q;
  logic        odd_q;
  logic [7:0]  hi_q;
  logic [7:0]  hold_q [2];
  logic [1:0]  fill_q;
  logic        open_q;

  fcgv_pkg::result_t due_results [$];
  fcgv_pkg::result_t want_r;
  int                fails = 0;

  assign fail_count = fails;

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  function automatic void restart_frame();
    crc_q     = init_q;
    sum_q     = 16'd0;
    par_q     = 1'b0;
    odd_q     = 1'b0;
    hi_q      = 8'd0;
    hold_q[0] = 8'd0;
    hold_q[1] = 8'd0;
    fill_q    = 2'd0;
    open_q    = 1'b0;
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    logic [15:0] c;
    par_q ^= ^b;
    if (odd_q) begin
      sum_q = ones_add(sum_q, {hi_q, b});
      odd_q = 1'b0;
    end else begin
      hi_q  = b;
      odd_q = 1'b1;
    end
    c = crc_q ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ poly_q;
      else       c = {c[14:0], 1'b0};
    end
    crc_q = c;
  endfunction

  function automatic logic [15:0] check_code();
    logic [15:0] s;
    case (method_q)
      fcgv_pkg::METHOD_EVEN: return {15'd0, par_q};
      fcgv_pkg::METHOD_ODD:  return {15'd0, ~par_q};
      fcgv_pkg::METHOD_CKSUM: begin
        s = sum_q;
        // pad a dangling byte as the high half of a word
        if (odd_q) s = ones_add(s, {hi_q, 8'h00});
        return ~s;
      end
      default: return crc_q;
    endcase
  endfunction

  function automatic void add_result(input logic [7:0] data, input logic [1:0] kind,
                                     input logic last, input logic ok);
    fcgv_pkg::result_t r;
    r.data = data;
    r.kind = kind;
    r.last = last;
    r.ok   = ok;
    due_results.insert(due_results.size(), r);
  endfunction

  function automatic void predict_frame_results(input logic [7:0] b, input logic lst);
    int          tlen;
    logic [15:0] c;
    logic [7:0]  rel;
    logic        ok;
    tlen   = (method_q == fcgv_pkg::METHOD_EVEN || method_q == fcgv_pkg::METHOD_ODD) ? 1 : 2;
    open_q = 1'b1;
    if (dir_q == fcgv_pkg::DIR_SENDER) begin
      absorb_byte(b);
      add_result(b, fcgv_pkg::KIND_PAYLOAD, 1'b0, 1'b0);
      if (lst) begin
        c = check_code();
        if (tlen == 1) begin
          add_result(c[7:0], fcgv_pkg::KIND_TRAILER, 1'b1, 1'b0);
        end else begin
          add_result(c[15:8], fcgv_pkg::KIND_TRAILER, 1'b0, 1'b0);
          add_result(c[7:0], fcgv_pkg::KIND_TRAILER, 1'b1, 1'b0);
        end
        restart_frame();
      end
    end else begin
      // release the oldest held byte; with a shorter trailer the surplus one drops
      if (fill_q >= tlen) begin
        rel = (tlen == 2) ? hold_q[1] : hold_q[0];
        absorb_byte(rel);
        add_result(rel, fcgv_pkg::KIND_PAYLOAD, 1'b0, 1'b0);
      end
      hold_q[1] = hold_q[0];
      hold_q[0] = b;
      fill_q    = 2'((fill_q + 1 > tlen) ? tlen : fill_q + 1);
      if (lst) begin
        ok = 1'b0;
        if (fill_q >= tlen) begin
          c = check_code();
          if (tlen == 1) ok = (hold_q[0][0] == c[0]);
          else           ok = ({hold_q[1], hold_q[0]} == c);
        end
        add_result(8'd0, fcgv_pkg::KIND_VERDICT, 1'b1, ok);
        restart_frame();
      end
    end
  endfunction

  function automatic void cmp_field(input string fld, input logic [7:0] want,
                                    input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, fld, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      method_q = fcgv_pkg::RESET_METHOD;
      dir_q    = fcgv_pkg::RESET_DIRECTION;
      poly_q   = fcgv_pkg::RESET_CRC_POLY;
      init_q   = fcgv_pkg::RESET_CRC_INIT;
      restart_frame();
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result: expected none actual byte %0h kind %0d",
                   $time, out_byte, out_kind);
          fails++;
        end else begin
          want_r = due_results.pop_front();
          cmp_field("out_byte", want_r.data, out_byte);
          cmp_field("out_kind", {6'd0, want_r.kind}, {6'd0, out_kind});
          cmp_field("out_last", {7'd0, want_r.last}, {7'd0, out_last});
          cmp_field("out_frame_ok", {7'd0, want_r.ok}, {7'd0, out_frame_ok});
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          fcgv_pkg::REG_METHOD:    method_q = pwdata[1:0];
          fcgv_pkg::REG_DIRECTION: dir_q    = pwdata[0];
          fcgv_pkg::REG_CRC_POLY:  poly_q   = pwdata[15:0];
          fcgv_pkg::REG_CRC_INIT: begin
            init_q = pwdata[15:0];
            // between frames the new start value loads at once
            if (!open_q) crc_q = init_q;
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_frame_results(in_byte, in_last);
    end
    pending_count <= due_results.size();
  end

endmodule

// File: test/frame_check_generate_verify_unit_tb.sv
// ----------------------------------------------------------------------------
// frame_check_generate_verify_unit_tb: stimulus and verdict for the frame unit
// Runs directed frames over every method, both directions, short frames and
// register changes inside a frame, then random phases of well-formed, corrupted,
// short and noise frames under random register settings and handshake idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frame_check_generate_verify_unit_tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 140;
  localparam int TAIL_CYCLES  = 4;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic [7:0]  in_byte   = 8'd0;
  logic        in_last   = 1'b0;
  logic        out_stall = 1'b0;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [3:0]  paddr     = 4'd0;
  logic [31:0] pwdata    = 32'd0;

  logic        in_stall;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic [1:0]  out_kind;
  logic        out_last;
  logic        out_frame_ok;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending_count;
  int cycles     = 0;
  int gap_max    = 10;
  int stall_max  = 10;
  int stall_left = 0;
  int sent       = 0;
  int directed   = 0;

  logic [1:0]  cur_method = fcgv_pkg::RESET_METHOD;
  logic        cur_dir    = fcgv_pkg::RESET_DIRECTION;
  logic [15:0] cur_poly   = fcgv_pkg::RESET_CRC_POLY;
  logic [15:0] cur_init   = fcgv_pkg::RESET_CRC_INIT;

  logic [7:0]  frame [$];
  logic [15:0] code;
  logic [7:0]  pb;
  int          tlen;
  int          len;
  int          shape;
  int          idx;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  frame_check_generate_verify_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .out_kind(out_kind), .out_last(out_last), .out_frame_ok(out_frame_ok),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  fcgv_result_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .out_kind(out_kind), .out_last(out_last), .out_frame_ok(out_frame_ok),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("frame_check_generate_verify_unit_tb: errors");
      $finish;
    end
  end

  // hold off the result side for a random count after each accepted result
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (out_valid && !out_stall) stall_left <= $urandom_range(0, stall_max);
    end
  end

  task automatic write_reg(input logic [1:0] ridx, input logic [15:0] val);
    case (ridx)
      fcgv_pkg::REG_METHOD:    cur_method = val[1:0];
      fcgv_pkg::REG_DIRECTION: cur_dir    = val[0];
      fcgv_pkg::REG_CRC_POLY:  cur_poly   = val;
      default:                 cur_init   = val;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ridx, 2'b00};
    pwdata  <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic lst);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= lst;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // drop valid and wait for every expected result, plus an idle tail for receiver
  // transactions that produce nothing
  task automatic settle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h1021;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // trailer value for the bytes now in the frame buffer
  function automatic logic [15:0] frame_code();
    logic [15:0] crc;
    logic [15:0] sum;
    logic        par;
    logic [16:0] t;
    logic [15:0] w;
    crc = cur_init;
    sum = 16'd0;
    par = 1'b0;
    foreach (frame[i]) begin
      par ^= ^frame[i];
      crc ^= {frame[i], 8'h00};
      for (int k = 0; k < 8; k++) begin
        if (crc[15]) crc = {crc[14:0], 1'b0} ^ cur_poly;
        else         crc = {crc[14:0], 1'b0};
      end
    end
    for (int i = 0; i < frame.size(); i += 2) begin
      w = {frame[i], (i + 1 < frame.size()) ? frame[i + 1] : 8'h00};
      t = {1'b0, sum} + {1'b0, w};
      sum = t[15:0] + {15'd0, t[16]};
    end
    case (cur_method)
      fcgv_pkg::METHOD_EVEN:  return {15'd0, par};
      fcgv_pkg::METHOD_ODD:   return {15'd0, ~par};
      fcgv_pkg::METHOD_CKSUM: return ~sum;
      default:                return crc;
    endcase
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // sender, one method per frame
    write_reg(fcgv_pkg::REG_METHOD, 16'(fcgv_pkg::METHOD_EVEN));
    push_byte(8'hA5, 1'b1);
    settle();
    write_reg(fcgv_pkg::REG_METHOD, 16'(fcgv_pkg::METHOD_ODD));
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    settle();
    write_reg(fcgv_pkg::REG_METHOD, 16'(fcgv_pkg::METHOD_CKSUM));
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'h56, 1'b1);
    settle();
    write_reg(fcgv_pkg::REG_METHOD, 16'(fcgv_pkg::METHOD_CRC));
    write_reg(fcgv_pkg::REG_CRC_POLY, 16'hFFFF);
    write_reg(fcgv_pkg::REG_CRC_INIT, 16'h0000);
    push_byte(8'h80, 1'b1);
    settle();

    // receiver: frame shorter than its trailer
    write_reg(fcgv_pkg::REG_DIRECTION, 16'(fcgv_pkg::DIR_RECEIVER));
    write_reg(fcgv_pkg::REG_METHOD, 16'(fcgv_pkg::METHOD_CKSUM));
    push_byte(8'h7E, 1'b1);
    settle();

    // receiver: trailer shrinks inside a frame, surplus held byte drops
    write_reg(fcgv_pkg::REG_METHOD, 16'(fcgv_pkg::METHOD_CRC));
    push_byte(8'h11, 1'b0);
    push_byte(8'h22, 1'b0);
    settle();
    write_reg(fcgv_pkg::REG_METHOD, 16'(fcgv_pkg::METHOD_EVEN));
    push_byte(8'h33, 1'b0);
    push_byte(8'h01, 1'b1);
    settle();

    // receiver parity: only bit 0 of the trailer counts
    write_reg(fcgv_pkg::REG_METHOD, 16'(fcgv_pkg::METHOD_ODD));
    push_byte(8'hC3, 1'b0);
    push_byte(8'hFF, 1'b1);
    settle();

    // direction flips inside a frame
    write_reg(fcgv_pkg::REG_DIRECTION, 16'(fcgv_pkg::DIR_SENDER));
    write_reg(fcgv_pkg::REG_METHOD, 16'(fcgv_pkg::METHOD_CKSUM));
    push_byte(8'hAB, 1'b0);
    settle();
    write_reg(fcgv_pkg::REG_DIRECTION, 16'(fcgv_pkg::DIR_RECEIVER));
    push_byte(8'hCD, 1'b0);
    push_byte(8'hEF, 1'b1);
    settle();

    // start value written inside a frame applies from the next frame
    write_reg(fcgv_pkg::REG_DIRECTION, 16'(fcgv_pkg::DIR_SENDER));
    write_reg(fcgv_pkg::REG_METHOD, 16'(fcgv_pkg::METHOD_CRC));
    write_reg(fcgv_pkg::REG_CRC_POLY, 16'h1021);
    write_reg(fcgv_pkg::REG_CRC_INIT, 16'hFFFF);
    push_byte(8'h5A, 1'b0);
    settle();
    write_reg(fcgv_pkg::REG_CRC_INIT, 16'h0000);
    push_byte(8'hA5, 1'b1);
    push_byte(8'hFF, 1'b1);
    directed = sent;

    while (sent < directed + RANDOM_ITEMS) begin
      settle();
      write_reg(fcgv_pkg::REG_METHOD, 16'($urandom_range(0, 3)));
      write_reg(fcgv_pkg::REG_DIRECTION, 16'($urandom_range(0, 1)));
      if ($urandom_range(0, 1)) write_reg(fcgv_pkg::REG_CRC_POLY, pick_word());
      if ($urandom_range(0, 1)) write_reg(fcgv_pkg::REG_CRC_INIT, pick_word());
      gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 10;
      stall_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
      tlen = (cur_method == fcgv_pkg::METHOD_EVEN || cur_method == fcgv_pkg::METHOD_ODD)
             ? 1 : 2;
      repeat ($urandom_range(2, 5)) begin
        frame.delete();
        len = (cur_dir == fcgv_pkg::DIR_SENDER) ? $urandom_range(1, 8) : $urandom_range(0, 6);
        repeat (len) frame.insert(frame.size(), 8'($urandom_range(0, 255)));
        if (cur_dir != fcgv_pkg::DIR_SENDER) begin
          shape = $urandom_range(0, 9);
          if (shape < 7) begin
            code = frame_code();
            if (tlen == 1) begin
              pb    = 8'($urandom_range(0, 255));
              pb[0] = code[0];
              frame.insert(frame.size(), pb);
            end else begin
              frame.insert(frame.size(), code[15:8]);
              frame.insert(frame.size(), code[7:0]);
            end
            // corrupt one bit now and then
            if (shape >= 5) begin
              idx = $urandom_range(0, frame.size() - 1);
              frame[idx] = frame[idx] ^ (8'h01 << $urandom_range(0, 7));
            end
          end else if (shape == 7 && tlen == 2) begin
            frame.delete();
            frame.insert(frame.size(), 8'($urandom_range(0, 255)));
          end
        end
        if (frame.size() == 0) frame.insert(frame.size(), 8'($urandom_range(0, 255)));
        foreach (frame[i]) push_byte(frame[i], i == frame.size() - 1);
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("frame_check_generate_verify_unit_tb: clean");
    end else begin
      $display("frame_check_generate_verify_unit_tb: errors");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/fcgv_pkg.sv
rtl/fcgv_engine.sv
rtl/frame_check_generate_verify_unit.sv
test/fcgv_result_checker.sv
test/frame_check_generate_verify_unit_tb.sv
